@@ design/mi3_pkg.sv @@
package mi3_pkg;

    localparam int ELEM_W   = 32;
    localparam int FRAC_DEF = 16;

    localparam int PROD_W = 2 * ELEM_W;
    localparam int COF_W  = 2 * ELEM_W + 1;
    localparam int PP_W   = 2 * ELEM_W + 1;
    localparam int DET_W  = 3 * ELEM_W + 2;
    localparam int CMAG_W = 2 * ELEM_W;
    localparam int DMAG_W = 3 * ELEM_W + 1;
    localparam int QUO_W  = ELEM_W + 3;

    localparam int NUM_ELEM = 9;
    localparam int NUM_PROD = 18;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a00;
        logic signed [ELEM_W-1:0] a01;
        logic signed [ELEM_W-1:0] a02;
        logic signed [ELEM_W-1:0] a10;
        logic signed [ELEM_W-1:0] a11;
        logic signed [ELEM_W-1:0] a12;
        logic signed [ELEM_W-1:0] a20;
        logic signed [ELEM_W-1:0] a21;
        logic signed [ELEM_W-1:0] a22;
    } in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] b00;
        logic signed [ELEM_W-1:0] b01;
        logic signed [ELEM_W-1:0] b02;
        logic signed [ELEM_W-1:0] b10;
        logic signed [ELEM_W-1:0] b11;
        logic signed [ELEM_W-1:0] b12;
        logic signed [ELEM_W-1:0] b20;
        logic signed [ELEM_W-1:0] b21;
        logic signed [ELEM_W-1:0] b22;
        logic                     singular;
    } out_t;

    // front end to divider lanes
    typedef struct packed {
        logic                                valid;
        logic                                singular;
        in_t                                 mat;
        logic [DMAG_W-1:0]                   dmag;
        logic [NUM_ELEM-1:0]                 neg;
        logic [NUM_ELEM-1:0][CMAG_W-1:0]     cmag;
    } fe_t;

    // cofactor k = P[2k] - P[2k+1], P[n] = a[PROD_L[n]] * a[PROD_R[n]]
    localparam logic [3:0] PROD_L [NUM_PROD] =
        '{4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
          4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
    localparam logic [3:0] PROD_R [NUM_PROD] =
        '{4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
          4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

    function automatic logic signed [ELEM_W-1:0] elem_of(input in_t m, input logic [3:0] k);
        logic signed [ELEM_W-1:0] e;
        case (k)
            4'd0: e = m.a00;
            4'd1: e = m.a01;
            4'd2: e = m.a02;
            4'd3: e = m.a10;
            4'd4: e = m.a11;
            4'd5: e = m.a12;
            4'd6: e = m.a20;
            4'd7: e = m.a21;
            4'd8: e = m.a22;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

@@ design/mi3_front.sv @@
module mi3_front import mi3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic valid,
    input  in_t  matrix,
    output fe_t  fe
);

    logic [4:0] vld_reg;
    in_t        mat_reg [5];

    logic signed [PROD_W-1:0] prod_reg  [NUM_PROD];
    logic signed [PROD_W-1:0] prod_next [NUM_PROD];
    logic signed [COF_W-1:0]  cof2_reg  [NUM_ELEM];
    logic signed [COF_W-1:0]  cof2_next [NUM_ELEM];
    logic signed [COF_W-1:0]  cof3_reg  [NUM_ELEM];
    logic signed [COF_W-1:0]  cof4_reg  [NUM_ELEM];
    logic signed [COF_W-1:0]  cof5_reg  [NUM_ELEM];
    logic signed [PP_W-1:0]   lo_reg    [3];
    logic signed [PP_W-1:0]   hi_reg    [3];
    logic signed [PP_W-1:0]   lo_next   [3];
    logic signed [PP_W-1:0]   hi_next   [3];
    logic signed [DET_W-1:0]  term_reg  [3];
    logic signed [DET_W-1:0]  term_next [3];
    logic signed [DET_W-1:0]  det_reg;
    logic signed [DET_W-1:0]  det_next;
    fe_t                      fe_reg;
    fe_t                      fe_next;

    always_comb
    begin
        for (int n = 0; n < NUM_PROD; n++)
        begin
            prod_next[n] = PROD_W'(elem_of(matrix, PROD_L[n])) *
                           PROD_W'(elem_of(matrix, PROD_R[n]));
        end
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            cof2_next[k] = COF_W'(prod_reg[2*k]) - COF_W'(prod_reg[2*k+1]);
        end
        // det = a0*c0 + a1*c3 + a2*c6, cofactor split in low and high halves
        for (int r = 0; r < 3; r++)
        begin
            lo_next[r] = PP_W'(elem_of(mat_reg[1], 4'(r))) *
                         PP_W'($signed({1'b0, cof2_reg[3*r][ELEM_W-1:0]}));
            hi_next[r] = PP_W'(elem_of(mat_reg[1], 4'(r))) *
                         PP_W'($signed(cof2_reg[3*r][COF_W-1:ELEM_W]));
            term_next[r] = (DET_W'(hi_reg[r]) <<< ELEM_W) + DET_W'(lo_reg[r]);
        end
        det_next = term_reg[0] + term_reg[1] + term_reg[2];

        fe_next.valid    = vld_reg[4];
        fe_next.singular = (det_reg == '0);
        fe_next.mat      = mat_reg[4];
        fe_next.dmag     = det_reg[DET_W-1] ? DMAG_W'(-det_reg) : DMAG_W'(det_reg);
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            fe_next.neg[k]  = cof5_reg[k][COF_W-1] ^ det_reg[DET_W-1];
            fe_next.cmag[k] = cof5_reg[k][COF_W-1] ? CMAG_W'(-cof5_reg[k])
                                                   : CMAG_W'(cof5_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            fe_reg  <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], valid};
            fe_reg  <= fe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mat_reg[0] <= matrix;
        for (int s = 1; s < 5; s++)
        begin
            mat_reg[s] <= mat_reg[s-1];
        end
        prod_reg <= prod_next;
        cof2_reg <= cof2_next;
        cof3_reg <= cof2_reg;
        cof4_reg <= cof3_reg;
        cof5_reg <= cof4_reg;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        term_reg <= term_next;
        det_reg  <= det_next;
    end

    assign fe = fe_reg;

endmodule

@@ design/mi3_div.sv @@
module mi3_div import mi3_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [CMAG_W-1:0] num,
    input  logic [DMAG_W-1:0] den,
    input  logic              neg_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic              neg_out
);

    // quotient of 2*num*2^(2F) / den; top bit flags overflow
    localparam int NUM_W  = CMAG_W + 2 * FRACTION_BITS + 1;
    localparam int SHR_W  = DMAG_W + QUO_W - 1;
    localparam int REM_W  = (NUM_W > SHR_W) ? NUM_W : SHR_W;
    localparam int STAGES = QUO_W;

    logic [REM_W-1:0]  rem_reg [STAGES-1];
    logic [DMAG_W-1:0] d_reg   [STAGES-1];
    logic [QUO_W-1:0]  q_reg   [STAGES];
    logic              neg_reg [STAGES];
    logic              vld_reg [STAGES];

    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        logic [REM_W-1:0]  rem_src;
        logic [REM_W-1:0]  den_sh;
        logic [DMAG_W-1:0] d_src;
        logic [QUO_W-1:0]  q_src;
        logic [QUO_W-1:0]  q_next;
        logic              n_src;
        logic              v_src;
        logic              ge;

        if (j == 0)
        begin : g_first
            assign rem_src = REM_W'({num, {(2 * FRACTION_BITS + 1){1'b0}}});
            assign d_src   = den;
            assign q_src   = '0;
            assign n_src   = neg_in;
            assign v_src   = in_valid;
        end
        else
        begin : g_rest
            assign rem_src = rem_reg[j-1];
            assign d_src   = d_reg[j-1];
            assign q_src   = q_reg[j-1];
            assign n_src   = neg_reg[j-1];
            assign v_src   = vld_reg[j-1];
        end

        always_comb
        begin
            den_sh = REM_W'(d_src) << (STAGES - 1 - j);
            ge     = (rem_src >= den_sh);
            q_next = ge ? (q_src | (QUO_W'(1) << (STAGES - 1 - j))) : q_src;
        end

        if (j < STAGES - 1)
        begin : g_keep
            logic [REM_W-1:0] rem_next;
            assign rem_next = ge ? (rem_src - den_sh) : rem_src;
            always_ff @(posedge clk)
            begin
                rem_reg[j] <= rem_next;
                d_reg[j]   <= d_src;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg[j]   <= q_next;
            neg_reg[j] <= n_src;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign quo       = q_reg[STAGES-1];
    assign neg_out   = neg_reg[STAGES-1];

endmodule

@@ design/matrix3_inverse_unit.sv @@
// channel   ports                    transfer when
// input     start, busy, matrix      start && !busy
// output    done, result             done (one cycle, no back-pressure)
//
// One matrix may enter every cycle. Depth is set by the restoring divider, one
// quotient bit per stage, nine lanes in parallel.
// busy is always low. Reset clears the valid bits and the front-end output
// register; items in flight are lost.
// The receiver cannot stall, so the pipeline never holds.
module matrix3_inverse_unit import mi3_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  matrix,
    output logic done,
    output out_t result
);

    localparam int DIV_LAT = QUO_W;
    localparam int LAT     = 6 + DIV_LAT + 1;
    localparam int MAG_W   = ELEM_W + 2;

    fe_t                 fe;
    logic [NUM_ELEM-1:0] div_vld;
    logic [QUO_W-1:0]    div_quo [NUM_ELEM];
    logic [NUM_ELEM-1:0] div_neg;

    in_t  mat_dly_reg  [DIV_LAT];
    logic sing_dly_reg [DIV_LAT];

    logic [ELEM_W-1:0] b_val [NUM_ELEM];
    out_t res_reg;
    out_t res_next;
    logic done_reg;

    assign busy = 1'b0;

    mi3_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (start),
        .matrix (matrix),
        .fe     (fe)
    );

    for (genvar k = 0; k < NUM_ELEM; k++)
    begin : g_lane
        mi3_div #(.FRACTION_BITS(FRACTION_BITS)) u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (fe.valid),
            .num       (fe.cmag[k]),
            .den       (fe.dmag),
            .neg_in    (fe.neg[k]),
            .out_valid (div_vld[k]),
            .quo       (div_quo[k]),
            .neg_out   (div_neg[k])
        );
    end

    always_ff @(posedge clk)
    begin
        mat_dly_reg[0]  <= fe.mat;
        sing_dly_reg[0] <= fe.singular;
        for (int s = 1; s < DIV_LAT; s++)
        begin
            mat_dly_reg[s]  <= mat_dly_reg[s-1];
            sing_dly_reg[s] <= sing_dly_reg[s-1];
        end
    end

    // round half up on magnitude, then saturate; a singular matrix is passed through with its flag set
    always_comb
    begin
        logic [QUO_W-1:0] rsum;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] lim;
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            rsum = {1'b0, div_quo[k][QUO_W-2:0]} + QUO_W'(1);
            mag  = rsum[QUO_W-1:1];
            lim  = div_neg[k] ? (MAG_W'(1) << (ELEM_W - 1))
                              : ((MAG_W'(1) << (ELEM_W - 1)) - MAG_W'(1));
            if (div_quo[k][QUO_W-1] || (mag > lim))
            begin
                mag = lim;
            end
            b_val[k] = div_neg[k] ? ELEM_W'(-mag) : ELEM_W'(mag);
        end
        if (sing_dly_reg[DIV_LAT-1])
        begin
            res_next = {mat_dly_reg[DIV_LAT-1], 1'b1};
        end
        else
        begin
            res_next = {b_val[0], b_val[1], b_val[2], b_val[3], b_val[4],
                        b_val[5], b_val[6], b_val[7], b_val[8], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld[0];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("transfer did not complete at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without matching input transfer");

    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (div_vld != '0) |-> (div_vld == '1))
        else $error("divider lanes out of step");

endmodule
